// File: hw/rtl/gf2_poly_power_mod_macros.svh
// ----------------------------------------------------------------------------
// gf2_poly_power_mod assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GF2_POLY_POWER_MOD_MACROS_SVH
`define GF2_POLY_POWER_MOD_MACROS_SVH

// same-cycle implication
`define GPM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gpm_pkg.sv
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types and constants for the GF(2) polynomial power unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

   // CSR map
   localparam logic CSR_IDX_MODULUS = 1'b0;
   localparam int   MOD_RESET_VALUE = 283;   // x^8+x^4+x^3+x+1

   typedef struct packed {
      logic start;
   } gpm_mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gpm_mul_sts_type;

   typedef struct packed {
      logic done;
      logic deg_zero;
   } gpm_scan_sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/gpm_mulmod.sv
// ----------------------------------------------------------------------------
// gpm_mulmod
// Bit-serial modular multiplier over GF(2), MSB-first interleaved reduction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_poly_power_mod_macros.svh"

module gpm_mulmod
   import gpm_pkg::*;
#(
   parameter int W = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire gpm_mul_ctl_type ctl,
   input  wire logic [W-1:0]    op_a,     // must be reduced, held during the op
   input  wire logic [W-1:0]    op_b,     // sampled at start, any value
   input  wire logic [W:0]      modulus,
   input  wire logic [W:0]      mod_top,  // one-hot top bit of modulus
   output logic [W-1:0]         product,
   output gpm_mul_sts_type      sts
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    reduced;

   always_comb begin
      shifted = {acc_ff, 1'b0};
      reduced = (|(shifted & mod_top)) ? (shifted ^ modulus) : shifted;
      acc_in  = acc_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in = '0;
         b_in   = op_b;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         acc_in  = reduced[W-1:0] ^ (b_ff[W-1] ? op_a : '0);
         b_in    = b_ff << 1;
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      b_ff   <= b_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign product  = acc_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;

   `GPM_ASSERT_IMP(a_no_start_busy, ctl.start, cnt_ff == '0, "mulmod started while busy")

endmodule

`default_nettype wire

// File: hw/rtl/gpm_deg_scan.sv
// ----------------------------------------------------------------------------
// gpm_deg_scan
// Finds the top set bit of the modulus by shifting it out MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_poly_power_mod_macros.svh"

module gpm_deg_scan
   import gpm_pkg::*;
#(
   parameter int W = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [W:0] modulus,
   output logic [W:0]      mod_top,
   output gpm_scan_sts_type sts
);

   logic [W:0] scan_ff, scan_in;
   logic [W:0] top_ff, top_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;

   always_comb begin
      scan_in = scan_ff;
      top_in  = top_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         scan_in = modulus;
         top_in  = {1'b1, {W{1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (scan_ff[W] || top_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            scan_in = scan_ff << 1;
            top_in  = top_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (reset) begin
         top_ff  <= {1'b1, {W{1'b0}}};
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         top_ff  <= top_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mod_top      = top_ff;
   assign sts.done     = done_ff;
   assign sts.deg_zero = top_ff[0];

   `GPM_ASSERT_IMP(a_top_onehot, 1'b1, $onehot(top_ff), "degree marker not one-hot")

endmodule

`default_nettype wire

// File: hw/rtl/gf2_poly_power_mod.sv
// Flow, acceptance to rsp_valid: a zero exponent goes straight to the finish; a degree-0 modulus
//   is caught by the degree scan and gives 0; else the degree scan, the base reduce, and per
//   exponent bit up to its top set bit a multiply into acc when the bit is set and a square,
//   then the finish.
// Throughput: one item at a time; the next is taken in the cycle the result is presented,
//   later while a previous result still sits stalled in the output register.
// Reset: synchronous, active high; modulus returns to 0x11B, no item in flight.
// ----------------------------------------------------------------------------
// gf2_poly_power_mod
// GF(2) polynomial exponentiation base^exponent mod modulus, square-and-
// multiply over one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_poly_power_mod_macros.svh"

module gf2_poly_power_mod
   import gpm_pkg::*;
#(
   parameter int MAX_DEGREE = 16,
   parameter int EXP_BITS   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input items
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [MAX_DEGREE-1:0] req_base_poly,
   input  wire logic [EXP_BITS-1:0]   req_exponent,
   // result items
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [MAX_DEGREE-1:0]      rsp_power_result,
   // CSR port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [((MAX_DEGREE + 1 > 32) ? 4 : 3)-1:0] paddr,
   input  wire logic [((MAX_DEGREE + 1 > 32) ? 64 : 32)-1:0] pwdata,
   output logic [((MAX_DEGREE + 1 > 32) ? 64 : 32)-1:0] prdata,
   output logic                       pready
);

   localparam int W      = MAX_DEGREE;
   localparam int MODW   = MAX_DEGREE + 1;
   localparam int CSR_DW = (MAX_DEGREE + 1 > 32) ? 64 : 32;
   localparam int ADDR_W = (MAX_DEGREE + 1 > 32) ? 4 : 3;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;   // finding modulus degree
   localparam logic [2:0] ST_PRE  = 3'd2;   // base = 1*base mod m
   localparam logic [2:0] ST_RND  = 3'd3;   // pick next exponent bit
   localparam logic [2:0] ST_MACC = 3'd4;   // acc = acc*base mod m
   localparam logic [2:0] ST_MSQR = 3'd5;   // base = base*base mod m
   localparam logic [2:0] ST_FIN  = 3'd6;   // hand acc to output register

   logic [MODW-1:0]     mod_ff, mod_in;
   logic [2:0]          state_ff, state_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        base_ff, base_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]        rsp_data_ff, rsp_data_in;

   logic                csr_idx;
   logic                csr_wr;

   gpm_mul_ctl_type     mul_ctl;
   gpm_mul_sts_type     mul_sts;
   logic [W-1:0]        mul_a;
   logic [W-1:0]        mul_p;
   logic [W:0]          mod_top;
   logic                scan_start;
   gpm_scan_sts_type    scan_sts;

   // ---------------------------------------------------------------------
   // CSR: one register, the modulus, at index 0. pready is tied high.
   // ---------------------------------------------------------------------
   assign csr_idx = paddr[ADDR_W-1];
   assign csr_wr  = psel && penable && pwrite && (csr_idx == CSR_IDX_MODULUS);
   assign pready  = 1'b1;
   assign prdata  = (csr_idx == CSR_IDX_MODULUS) ? CSR_DW'(mod_ff) : '0;
   assign mod_in  = csr_wr ? pwdata[MODW-1:0] : mod_ff;

   // ---------------------------------------------------------------------
   // Datapath units
   // ---------------------------------------------------------------------
   gpm_deg_scan #(.W(W)) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .modulus (mod_ff),
      .mod_top (mod_top),
      .sts     (scan_sts)
   );

   // op_b is always the running base; op_a is acc except while squaring.
   // op_a is consumed starting the cycle after start, when state is settled.
   assign mul_a = (state_ff == ST_MSQR) ? base_ff : acc_ff;

   gpm_mulmod #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (mul_a),
      .op_b    (base_ff),
      .modulus (mod_ff),
      .mod_top (mod_top),
      .product (mul_p),
      .sts     (mul_sts)
   );

   // ---------------------------------------------------------------------
   // Sequencer: square-and-multiply, LSB of exponent first. Stops early once
   // the remaining exponent bits are all zero.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      mul_ctl.start = 1'b0;
      scan_start    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in = req_base_poly;
               exp_in  = req_exponent;
               acc_in  = W'(1);
               if (req_exponent == '0) begin
                  // zero exponent: result is 1 whatever base or modulus
                  state_in = ST_FIN;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_sts.done) begin
               if (scan_sts.deg_zero) begin
                  // modulus 0 or 1: everything reduces to 0
                  acc_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  mul_ctl.start = 1'b1;
                  state_in      = ST_PRE;
               end
            end
         end
         ST_PRE: begin
            if (mul_sts.done) begin
               base_in  = mul_p;
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            mul_ctl.start = (exp_ff != '0);
            if (exp_ff == '0) begin
               state_in = ST_FIN;
            end else if (exp_ff[0]) begin
               state_in = ST_MACC;
            end else begin
               state_in = ST_MSQR;
            end
         end
         ST_MACC: begin
            if (mul_sts.done) begin
               acc_in        = mul_p;
               mul_ctl.start = 1'b1;
               state_in      = ST_MSQR;
            end
         end
         ST_MSQR: begin
            if (mul_sts.done) begin
               base_in  = mul_p;
               exp_in   = exp_ff >> 1;
               state_in = ST_RND;
            end
         end
         ST_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         mod_ff       <= MODW'(MOD_RESET_VALUE);
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_ff       <= mod_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

   `GPM_ASSERT_IMP(a_mul_done_state, mul_sts.done,
      (state_ff == ST_PRE) || (state_ff == ST_MACC) || (state_ff == ST_MSQR),
      "multiplier finished outside a wait state")
   `GPM_ASSERT_IMP(a_mul_done_idle, mul_sts.done, !mul_sts.busy,
      "multiplier reports done while still busy")
   `GPM_ASSERT_IMP(a_scan_done_state, scan_sts.done, state_ff == ST_SCAN,
      "degree scan finished outside scan state")
   `GPM_ASSERT_NEXT(a_fin_delivers, (state_ff == ST_FIN) && !(rsp_valid_ff && rsp_stall),
      rsp_valid_ff && (state_ff == ST_IDLE), "finished item not presented")

endmodule

`default_nettype wire

// File: test/gf2_poly_power_mod_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_power_mod_tb
// Self-checking bench for the GF(2) polynomial power unit. Items flow from a
// queue through a clocked driver with random gaps. A clocked monitor stalls
// at random and compares every result with an in-bench square-and-multiply
// predictor. The modulus register is rewritten over the APB port between
// phases, each time with the datapath drained.
// ----------------------------------------------------------------------------

module gf2_poly_power_mod_tb
   import gpm_pkg::*;
();

   localparam int          NUM_PHASES     = 8;
   localparam int          ITEMS_PER_PHASE = 65;
   localparam int          DRAIN_CYCLES   = 1200;   // worst-case latency, with margin
   localparam logic [2:0]  MODULUS_ADDR   = 3'(4 * CSR_IDX_MODULUS);
   localparam logic [2:0]  SPARE_ADDR     = 3'd4;   // first address past the map

   typedef struct packed {
      logic [15:0] base;
      logic [31:0] exponent;
   } power_req_type;

   typedef struct packed {
      logic [15:0] base;
      logic [31:0] exponent;
      logic [15:0] power;
   } power_expect_type;

   // ------------------------------------------------------------------------
   // clock, reset and DUT-facing signals; every input known from time zero
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_base_poly = '0;
   logic [31:0] req_exponent = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_power_result;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gf2_poly_power_mod dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_poly    (req_base_poly),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   power_req_type    pending_items[$];      // items not yet offered to the DUT
   power_expect_type expected_powers[$];    // predicted results, oldest first
   logic [16:0]   modulus_copy = 17'(MOD_RESET_VALUE);
   bit            no_idle = 1'b0;        // phase without gaps or stalls
   int            send_gap = 0;
   int            stall_left = 0;
   int            items_accepted = 0;
   int            results_checked = 0;
   int            mismatches = 0;
   int            failures = 0;
   int            modulus_writes = 0;

   // ------------------------------------------------------------------------
   // predictor: carry-less multiply, GF(2) remainder, square-and-multiply
   // ------------------------------------------------------------------------
   function automatic logic [63:0] clmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < 32; i++)
         if (b[i]) acc ^= a << i;
      return acc;
   endfunction

   function automatic logic [63:0] poly_remainder(logic [63:0] v, logic [63:0] m, int dm);
      for (int i = 63; i >= dm; i--)
         if (v[i]) v ^= m << (i - dm);
      return v;
   endfunction

   function automatic logic [15:0] expected_power(logic [15:0] base, logic [31:0] e,
                                                  logic [16:0] m);
      logic [63:0] sq;
      logic [63:0] acc;
      logic [63:0] mm;
      int          dm;
      if (e == '0) return 16'd1;
      dm = 0;
      for (int i = 0; i < 17; i++)
         if (m[i]) dm = i;
      // degree-0 modulus: everything reduces to zero
      if (dm == 0) return 16'd0;
      mm  = 64'(m);
      sq  = poly_remainder(64'(base), mm, dm);
      acc = 64'd1;
      for (int k = 0; k < 32; k++) begin
         if (e[k]) acc = poly_remainder(clmul(acc, sq), mm, dm);
         sq = poly_remainder(clmul(sq, sq), mm, dm);
      end
      return acc[15:0];
   endfunction

   // mostly short idles, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // exponent with a random top bit, so latency spreads over its full range
   function automatic logic [31:0] random_exponent();
      int          top;
      logic [31:0] e;
      top = $urandom_range(0, 32);
      if (top == 0) return '0;
      e = $urandom;
      e[top-1] = 1'b1;
      if (top < 32) e &= (32'd1 << top) - 32'd1;
      return e;
   endfunction

   function automatic logic [15:0] random_base();
      case ($urandom_range(0, 15))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'hFFFF;
         3:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // driver: offers queued items, predicts on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      power_req_type    nxt;
      power_expect_type exp_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_item.base     = req_base_poly;
            exp_item.exponent = req_exponent;
            exp_item.power    = expected_power(req_base_poly, req_exponent, modulus_copy);
            expected_powers.push_back(exp_item);
            items_accepted++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled item as it is
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            nxt = pending_items.pop_front();
            req_base_poly <= nxt.base;
            req_exponent  <= nxt.exponent;
            req_valid     <= 1'b1;
            send_gap = no_idle ? 0 : idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: random stall, compare accepted results in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      power_expect_type exp_item;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               failures++;
               $display("unexpected result %h with nothing outstanding", rsp_power_result);
            end else begin
               exp_item = expected_powers.pop_front();
               results_checked++;
               if (rsp_power_result !== exp_item.power) begin
                  mismatches++;
                  failures++;
                  if (mismatches <= 10)
                     $display("mismatch: base %h exp %h: expected %h, got %h",
                              exp_item.base, exp_item.exponent, exp_item.power,
                              rsp_power_result);
               end
            end
         end
         if (no_idle) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_len();
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // APB write: setup, access, done at the edge where pready is seen;
   // then the register is read back
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // register updates at this edge; bits above 16 are dropped
      if (addr == MODULUS_ADDR) begin
         modulus_copy = data[16:0];
         modulus_writes++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == MODULUS_ADDR && prdata !== 32'(modulus_copy)) begin
         failures++;
         $display("modulus readback: expected %h, got %h", 32'(modulus_copy), prdata);
      end
   endtask

   // sender holds off until every outstanding result has come back;
   // sampled mid-cycle so the driver's updates at the edge have landed
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_powers.size() != 0);
   endtask

   task automatic queue_item(logic [15:0] base, logic [31:0] e);
      power_req_type it;
      it.base     = base;
      it.exponent = e;
      pending_items.push_back(it);
   endtask

   // ------------------------------------------------------------------------
   // sequence: reset, directed items, then phases over several moduli
   // ------------------------------------------------------------------------
   initial begin : run_test
      logic [31:0] mod_word;
      int          deg;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value again, with junk above bit 16 that must be dropped
      csr_write(MODULUS_ADDR, 32'hFFFE_011B);

      // zero exponent returns one, whatever the base
      queue_item(16'h0000, 32'h0000_0000);
      queue_item(16'hFFFF, 32'h0000_0000);
      // zero base with nonzero exponent
      queue_item(16'h0000, 32'h0000_0001);
      queue_item(16'h0000, 32'hFFFF_FFFF);
      // unreduced bases and a small reduced one, exponent one
      queue_item(16'hFFFF, 32'h0000_0001);
      queue_item(16'h8000, 32'h0000_0001);
      queue_item(16'h0002, 32'h0000_0001);
      // field extremes
      queue_item(16'hFFFF, 32'hFFFF_FFFF);
      queue_item(16'h0001, 32'hFFFF_FFFF);
      queue_item(16'h0002, 32'h8000_0000);
      queue_item(16'h0003, 32'h0000_00FF);
      queue_item(16'hAAAA, 32'h5555_5555);
      queue_item(16'h5555, 32'hAAAA_AAAA);
      queue_item(16'h1234, 32'h0000_0002);
      queue_item(16'h00FF, 32'h0000_0003);
      queue_item(16'h0053, 32'h0000_00FE);   // inverse via a^(2^8-2)
      queue_item(16'hFFFE, 32'h7FFF_FFFF);
      queue_item(16'h0001, 32'h0000_0000);
      queue_item(16'h8001, 32'h0001_0000);
      queue_item(16'h0100, 32'h0000_0005);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            case (p)
               1: mod_word = 32'h0000_0002;            // x, lowest degree
               2: mod_word = 32'h0001_FFFF;            // all ones, degree 16
               3: mod_word = 32'h0001_002B;            // degree-16 trinomial-ish
               4: mod_word = 32'hA5A4_0003;            // x+1 with high junk
               5: mod_word = $urandom_range(2, 131071) | ($urandom & 32'hFFFE_0000);
               default: begin
                  deg = $urandom_range(1, 16);
                  mod_word = (32'd1 << deg) | ($urandom & ((32'd1 << deg) - 1));
               end
            endcase
            // address past the map: must not disturb the modulus
            if (p == NUM_PHASES - 1) csr_write(SPARE_ADDR, $urandom);
            csr_write(MODULUS_ADDR, mod_word);
         end
         no_idle = (p == 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_item(random_base(), random_exponent());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_powers.size() != 0) begin
         failures += expected_powers.size();
         $display("%0d results never arrived", expected_powers.size());
      end
      $display("run covered %0d items under %0d modulus writes, %0d results compared",
               items_accepted, modulus_writes, results_checked);
      $display("mismatches %0d, total failures %0d", mismatches, failures);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #(50_000_000);
      $display("timeout with %0d results outstanding", expected_powers.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
